// ===== src/rtc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared constants, word types and controller/datapath interface types for
// the record table compactor.
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int RECORD_COUNT     = 128;
  localparam int WORDS_PER_RECORD = 8;
  localparam int STORE_DEPTH      = RECORD_COUNT * WORDS_PER_RECORD;
  localparam int DATA_W           = 64;
  localparam int MARKER_W         = 8;

  localparam int ADDR_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SLOT_IDX_W = $clog2(RECORD_COUNT);
  localparam int CNT_W      = $clog2(RECORD_COUNT + 1);
  localparam int WIDX_W     = (WORDS_PER_RECORD > 1) ? $clog2(WORDS_PER_RECORD) : 1;
  localparam int FIND_LIMIT = (RECORD_COUNT < 128) ? RECORD_COUNT : 128;
  localparam int LIVE_MAX   = 255;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_COMPACT = 2'd2,
    REQ_FIND    = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [6:0]  slot;
    logic [2:0]  word_index;
    logic [63:0] write_data;
  } request_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        found;
    logic [6:0]  free_slot;
    logic [7:0]  live_count;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_C_CHK,
    S_C_EVAL,
    S_C_CPRD,
    S_C_CPWR,
    S_C_CLR,
    S_T_CHK,
    S_T_EVAL,
    S_F_CHK,
    S_F_EVAL
  } state_e;

  typedef enum logic [1:0] {
    RD_REQ,
    RD_SRC_W0,
    RD_SRC_WORD,
    RD_DST_W0
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_CLEAR,
    WR_REQ,
    WR_COPY,
    WR_SRC_MARK,
    WR_DST_MARK
  } wr_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_READ,
    RES_LIVE,
    RES_FOUND
  } res_sel_e;

  typedef struct packed {
    logic     clr_step;
    rd_sel_e  rd_sel;
    logic     we;
    wr_sel_e  wr_sel;
    logic     ptr_init;
    logic     src_inc;
    logic     dst_inc;
    logic     k_init;
    logic     k_inc;
    logic     hold_load;
    logic     live_load;
    logic     req_load;
    logic     res_load;
    res_sel_e res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    req_type_e req_type;
    logic      addr_ok;
    logic      clr_last;
    logic      src_end;
    logic      dst_end;
    logic      find_end;
    logic      marker_live;
    logic      src_eq_dst;
    logic      k_last;
  } ctrl_status_t;

  function automatic logic [ADDR_W-1:0] rec_addr(input logic [SLOT_IDX_W-1:0] s,
                                                 input logic [WIDX_W-1:0]     w);
    logic [ADDR_W:0] full;
    full = (ADDR_W+1)'(s) * (ADDR_W+1)'(WORDS_PER_RECORD) + (ADDR_W+1)'(w);
    return full[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/rtc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/rtc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_ctrl
// Controller: sequences the clearing pass, word requests, the compaction
// walk, the tail marker clear and the find-free scan.
// ----------------------------------------------------------------------------
module rtc_ctrl import rtc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire ctrl_status_t status,
  output logic              busy,
  output ctrl_cmd_t         cmd
);

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (status.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          unique case (status.req_type)
            REQ_WRITE:   state_next = S_IDLE;
            REQ_READ:    state_next = S_READ;
            REQ_COMPACT: state_next = S_C_CHK;
            REQ_FIND:    state_next = S_F_CHK;
          endcase
        end
      end
      S_READ:   state_next = S_IDLE;
      S_C_CHK:  state_next = status.src_end ? S_T_CHK : S_C_EVAL;
      S_C_EVAL: begin
        if (status.marker_live && !status.src_eq_dst) begin
          state_next = S_C_CPRD;
        end else begin
          state_next = S_C_CHK;
        end
      end
      S_C_CPRD: state_next = S_C_CPWR;
      S_C_CPWR: state_next = status.k_last ? S_C_CLR : S_C_CPRD;
      S_C_CLR:  state_next = S_C_CHK;
      S_T_CHK:  state_next = status.dst_end ? S_IDLE : S_T_EVAL;
      S_T_EVAL: state_next = S_T_CHK;
      S_F_CHK:  state_next = status.find_end ? S_IDLE : S_F_EVAL;
      S_F_EVAL: state_next = status.marker_live ? S_F_CHK : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.we       = 1'b1;
        cmd.wr_sel   = WR_CLEAR;
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        cmd.rd_sel = RD_REQ;
        if (start) begin
          unique case (status.req_type)
            REQ_WRITE: begin
              cmd.we       = status.addr_ok;
              cmd.wr_sel   = WR_REQ;
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ZERO;
            end
            REQ_READ:    cmd.req_load = 1'b1;
            REQ_COMPACT: cmd.ptr_init = 1'b1;
            REQ_FIND:    cmd.ptr_init = 1'b1;
          endcase
        end
      end
      S_READ: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_READ;
      end
      S_C_CHK: begin
        cmd.rd_sel    = RD_SRC_W0;
        cmd.live_load = status.src_end;
      end
      S_C_EVAL: begin
        cmd.hold_load = 1'b1;
        cmd.k_init    = 1'b1;
        if (status.marker_live) begin
          if (status.src_eq_dst) begin
            cmd.src_inc = 1'b1;
            cmd.dst_inc = 1'b1;
          end
        end else begin
          cmd.src_inc = 1'b1;
        end
      end
      S_C_CPRD: cmd.rd_sel = RD_SRC_WORD;
      S_C_CPWR: begin
        cmd.we     = 1'b1;
        cmd.wr_sel = WR_COPY;
        cmd.k_inc  = 1'b1;
      end
      S_C_CLR: begin
        cmd.we      = 1'b1;
        cmd.wr_sel  = WR_SRC_MARK;
        cmd.src_inc = 1'b1;
        cmd.dst_inc = 1'b1;
      end
      S_T_CHK: begin
        cmd.rd_sel   = RD_DST_W0;
        cmd.res_load = status.dst_end;
        cmd.res_sel  = RES_LIVE;
      end
      S_T_EVAL: begin
        cmd.we      = 1'b1;
        cmd.wr_sel  = WR_DST_MARK;
        cmd.dst_inc = 1'b1;
      end
      S_F_CHK: begin
        cmd.rd_sel   = RD_SRC_W0;
        cmd.res_load = status.find_end;
        cmd.res_sel  = RES_ZERO;
      end
      S_F_EVAL: begin
        cmd.src_inc  = status.marker_live;
        cmd.res_load = !status.marker_live;
        cmd.res_sel  = RES_FOUND;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/rtc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_datapath
// Record store, slot/word pointers, address and data selection, and the
// result register with its done strobe.
// ----------------------------------------------------------------------------
module rtc_datapath import rtc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire request_t  request,
  input  wire ctrl_cmd_t cmd,
  output ctrl_status_t   status,
  output logic           done,
  output result_t        result
);

  logic [ADDR_W-1:0]     clr_cnt;
  logic [CNT_W-1:0]      src;
  logic [CNT_W-1:0]      dst;
  logic [CNT_W-1:0]      live;
  logic [WIDX_W-1:0]     k;
  logic [DATA_W-1:0]     hold;
  logic                  read_ok;

  logic [SLOT_IDX_W-1:0] src_idx;
  logic [SLOT_IDX_W-1:0] dst_idx;
  logic [ADDR_W-1:0]     req_addr;
  logic                  addr_ok;
  logic [ADDR_W-1:0]     raddr;
  logic [ADDR_W-1:0]     waddr;
  logic [DATA_W-1:0]     wdata;
  logic [DATA_W-1:0]     rd_data;
  logic [7:0]            live_sat;
  result_t               result_next;

  assign src_idx  = src[SLOT_IDX_W-1:0];
  assign dst_idx  = dst[SLOT_IDX_W-1:0];
  assign addr_ok  = (32'(request.slot) < 32'(RECORD_COUNT)) &&
                    (32'(request.word_index) < 32'(WORDS_PER_RECORD));
  assign req_addr = rec_addr(SLOT_IDX_W'(request.slot), WIDX_W'(request.word_index));
  assign live_sat = (32'(live) > 32'(LIVE_MAX)) ? 8'(LIVE_MAX) : 8'(live);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_REQ:      raddr = req_addr;
      RD_SRC_W0:   raddr = rec_addr(src_idx, '0);
      RD_SRC_WORD: raddr = rec_addr(src_idx, k);
      RD_DST_W0:   raddr = rec_addr(dst_idx, '0);
      default:     raddr = req_addr;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_CLEAR: begin
        waddr = clr_cnt;
        wdata = '0;
      end
      WR_REQ: begin
        waddr = req_addr;
        wdata = request.write_data;
      end
      WR_COPY: begin
        waddr = rec_addr(dst_idx, k);
        wdata = rd_data;
      end
      WR_SRC_MARK: begin
        waddr = rec_addr(src_idx, '0);
        wdata = {hold[DATA_W-1:MARKER_W], {MARKER_W{1'b0}}};
      end
      WR_DST_MARK: begin
        waddr = rec_addr(dst_idx, '0);
        wdata = {rd_data[DATA_W-1:MARKER_W], {MARKER_W{1'b0}}};
      end
      default: begin
        waddr = clr_cnt;
        wdata = '0;
      end
    endcase
  end

  rtc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_init) begin
      src <= '0;
      dst <= '0;
    end else begin
      if (cmd.src_inc) src <= src + CNT_W'(1);
      if (cmd.dst_inc) dst <= dst + CNT_W'(1);
    end
    if (cmd.k_init) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + WIDX_W'(1);
    end
    if (cmd.hold_load) hold <= rd_data;
    if (cmd.live_load) live <= dst;
    if (cmd.req_load)  read_ok <= addr_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_load;
    end
  end

  always_comb begin
    result_next = '0;
    unique case (cmd.res_sel)
      RES_ZERO:  result_next = '0;
      RES_READ:  result_next.read_data = read_ok ? rd_data : '0;
      RES_LIVE:  result_next.live_count = live_sat;
      RES_FOUND: begin
        result_next.found     = 1'b1;
        result_next.free_slot = 7'(src);
      end
      default:   result_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result <= result_next;
    end
  end

  always_comb begin
    status.req_type    = request.req_type;
    status.addr_ok     = addr_ok;
    status.clr_last    = (clr_cnt == ADDR_W'(STORE_DEPTH - 1));
    status.src_end     = (src == CNT_W'(RECORD_COUNT));
    status.dst_end     = (dst == CNT_W'(RECORD_COUNT));
    status.find_end    = (src == CNT_W'(FIND_LIMIT));
    status.marker_live = (rd_data[MARKER_W-1:0] != '0);
    status.src_eq_dst  = (src == dst);
    status.k_last      = (k == WIDX_W'(WORDS_PER_RECORD - 1));
  end

endmodule
`default_nettype wire

// ===== src/record_table_compactor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// record_table_compactor
// Table of marked records with word access, find-free and compaction.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; every request returns
// one result word on result, valid for the single cycle in which done is
// high. The receiver cannot stall, so done must be sampled every cycle.
// After reset the block sweeps the record store to zero, one word per cycle,
// with busy high until its RECORD_COUNT*WORDS_PER_RECORD (1024) words clear.
// The store has a single read port with registered read data: a write is
// done from idle (back to back), a read waits in S_READ for its data,
// find-free reads and checks each slot examined, and compaction reads and
// checks each slot scanned, copies each word of a moving record by a read
// and a write, clears its old marker and then each marker past the new end.
module record_table_compactor import rtc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire request_t request,
  output logic          busy,
  output logic          done,
  output result_t       result
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  rtc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  rtc_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .done    (done),
    .result  (result)
  );

endmodule
`default_nettype wire
